// File: hdl/gwm_pkg.sv
// gwm_pkg: shared types, constants and the star-closure function for the
// glob word matcher. No dependencies.
package gwm_pkg;

  localparam int MASK_CHARS = 16;
  localparam int POS_W      = MASK_CHARS + 1;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [MASK_CHARS-1:0][7:0]    mask_t;
  typedef logic [MASK_CHARS-1:0]         flags_t;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] PATTERN_LOW_RESET  = 64'd42;
  localparam logic [CFG_DATA_W-1:0] PATTERN_HIGH_RESET = 64'd0;
  localparam len_t                  PATTERN_LEN_RESET  = 5'd1;

  // position zero closed over the reset mask "*"
  localparam pos_t ACTIVE_RESET = pos_t'(3);

  // Cut to positions 0..len, then let every active position that sits on a
  // star also activate the one after it. Done as a flat prefix: position j is
  // set if some active i <= j has only stars between i and j. Positions past
  // len never get set, whatever the mask holds there.
  function automatic pos_t star_closure(pos_t v, flags_t star, len_t len);
    pos_t cut;
    pos_t res;
    pos_t star_x;
    pos_t rng;
    star_x = {1'b0, star};
    for (int j = 0; j < POS_W; j++) begin
      cut[j] = v[j] & (LEN_W'(j) <= len);
    end
    for (int j = 0; j < POS_W; j++) begin
      res[j] = 1'b0;
      for (int i = 0; i <= j; i++) begin
        rng = ((pos_t'(1) << j) - pos_t'(1)) & ~((pos_t'(1) << i) - pos_t'(1));
        res[j] = res[j] | (cut[i] & (&(star_x | ~rng)));
      end
      res[j] = res[j] & (LEN_W'(j) <= len);
    end
    return res;
  endfunction

endpackage

// File: hdl/glob_word_matcher.sv
// glob_word_matcher: top level of the streaming glob word matcher.
// Depends on gwm_pkg and gwm_step.
//
// Matches words, one byte per transfer, against a glob mask of up to 16
// characters held in three config registers: '*' matches any run of bytes
// (also empty), '?' exactly one byte, anything else must match exactly (case
// sensitive). A set of active mask positions is kept; each byte advances it.
// The byte flagged last_char yields one transfer on the match channel and
// restarts the set; other bytes yield nothing. Throughput is one byte per
// clock: the byte is captured in an input register, and the whole position
// update (star closure, compare, closure again) sits between that register
// and the state/result registers. A byte passes the input register, then the
// result register. The input side stalls only while a finished result is
// held in the output register and the byte waiting in the input register is
// itself a last byte. pattern_length above 16 is treated as 16; zero never
// matches. Config writes are always accepted and take effect on the next
// byte; the active set survives a write and is re-cut to the new length.
module glob_word_matcher (
  input  logic                             clk,
  input  logic                             rst,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // character input channel
  input  logic                             word_valid,
  output logic                             word_ready,
  input  logic [7:0]                       word_char,
  input  logic                             last_char,
  // result channel
  output logic                             match_valid,
  input  logic                             match_ready,
  output logic                             matched
);
  import gwm_pkg::*;

  // config registers
  logic [CFG_DATA_W-1:0] pattern_bytes_low;
  logic [CFG_DATA_W-1:0] pattern_bytes_high;
  len_t                  pattern_length;
  len_t                  len;
  mask_t                 mask;

  // input register
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_last;

  // position state
  pos_t active;
  pos_t active_next;
  pos_t restart;
  logic step_match;

  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= PATTERN_LOW_RESET;
      pattern_bytes_high <= PATTERN_HIGH_RESET;
      pattern_length     <= PATTERN_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        CFG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        CFG_PATTERN_LEN:  pattern_length     <= cfg_data[LEN_W-1:0];
        default: ;        // unused index, write dropped
      endcase
    end
  end

  // saturate length to the mask size
  assign len  = (pattern_length > LEN_W'(MASK_CHARS)) ? LEN_W'(MASK_CHARS)
                                                       : pattern_length;
  assign mask = mask_t'({pattern_bytes_high, pattern_bytes_low});

  // Held byte moves on unless it is a last byte and the result slot is full.
  assign advance    = stage_valid && (!stage_last || !match_valid || match_ready);
  assign word_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (word_ready) begin
      stage_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      stage_char <= word_char;
      stage_last <= last_char;
    end
  end

  gwm_step u_step (
    .active      (active),
    .mask        (mask),
    .len         (len),
    .word_char   (stage_char),
    .active_next (active_next),
    .restart     (restart),
    .matched     (step_match)
  );

  // On a word end the set restarts at position zero, closed over the
  // current mask, as the stored state must reflect the mask at that time.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACTIVE_RESET;
    end else if (advance) begin
      active <= stage_last ? restart : active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (advance && stage_last) begin
      match_valid <= 1'b1;
    end else if (match_ready) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      matched <= step_match;
    end
  end

endmodule

// File: hdl/gwm_step.sv
// gwm_step: one character step of the glob position vector.
// Depends on gwm_pkg.
module gwm_step (
  input  gwm_pkg::pos_t  active,
  input  gwm_pkg::mask_t mask,
  input  gwm_pkg::len_t  len,
  input  logic [7:0]     word_char,
  output gwm_pkg::pos_t  active_next,
  output gwm_pkg::pos_t  restart,
  output logic           matched
);
  import gwm_pkg::*;

  flags_t star;
  flags_t hit;
  flags_t in_use;
  pos_t   cur;
  pos_t   adv;

  always_comb begin
    for (int i = 0; i < MASK_CHARS; i++) begin
      star[i]   = (mask[i] == STAR_CHAR);
      hit[i]    = (mask[i] == QMARK_CHAR) || (mask[i] == word_char);
      in_use[i] = (LEN_W'(i) < len);
    end
  end

  assign cur = star_closure(active, star, len);

  always_comb begin
    adv = '0;
    for (int i = 0; i < MASK_CHARS; i++) begin
      if (cur[i] && in_use[i]) begin
        if (star[i]) begin
          adv[i] = 1'b1;
        end else if (hit[i]) begin
          adv[i+1] = 1'b1;
        end
      end
    end
  end

  assign active_next = star_closure(adv, star, len);
  assign restart     = star_closure(pos_t'(1), star, len);
  assign matched     = active_next[len];

endmodule

// File: hdl/gwm_checker.sv
// gwm_checker: port-level assertions for glob_word_matcher, bound to it below.
// Depends on glob_word_matcher.
module gwm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           word_ready,
  input logic                           match_valid,
  input logic                           match_ready,
  input logic                           matched
);

  // a held result does not change or vanish
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    match_valid && !match_ready |=> match_valid && $stable(matched))
    else $error("result changed while stalled");

  // empty result slot never blocks characters
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !match_valid |-> word_ready)
    else $error("input stalled with empty result slot");

  // config writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !match_valid)
    else $error("result present after reset");

endmodule

bind glob_word_matcher gwm_checker u_gwm_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready),
  .word_ready  (word_ready),
  .match_valid (match_valid),
  .match_ready (match_ready),
  .matched     (matched)
);

// File: dv/testbench.sv
// testbench: self-checking bench for glob_word_matcher, a directed table then random words.
// Depends on gwm_pkg and glob_word_matcher; has its own bit-level predictor of the matcher.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gwm_pkg::*;

  // no transfer on any channel for this many cycles ends the run
  localparam int WATCHDOG_LIMIT = 2000;
  // a byte passes the input register, then the result register; leave margin when draining
  localparam int DRAIN_CYCLES   = 4;
  localparam int TARGET_CHARS   = 1000;
  // from this many sent chars on, neither side inserts gaps
  localparam int QUIET_FROM     = 880;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_e;

  // One directed stimulus row: a register write or one char. has_exp marks
  // rows whose match bit is typed in; all other rows take the predictor.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] data;
    logic [7:0]            ch;
    logic                  last;
    logic                  has_exp;
    logic                  exp_match;
  } stim_row_t;

  localparam int N_DIR = 35;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // mask after reset is a lone star: any word matches
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h00, 1'b1, 1'b1, 1'b1},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h78, 1'b1, 1'b1, 1'b1},
    // mask "a?*b": literal, question mark, star, literal
    '{ROW_CFG,  CFG_PATTERN_LOW,  64'h0000_0000_622A_3F61, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd4, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h61, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h78, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h62, 1'b1, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h61, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h62, 1'b1, 1'b0, 1'b0},
    // upper case must not match a lower case literal
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h41, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h62, 1'b1, 1'b0, 1'b0},
    // empty mask never matches a (non-empty) word
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h71, 1'b1, 1'b1, 1'b0},
    // eight stars then eight 0xFF bytes, length 31 saturates to 16
    '{ROW_CFG,  CFG_PATTERN_LOW,  64'h2A2A_2A2A_2A2A_2A2A, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd31, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'hFF, 1'b1, 1'b0, 1'b0},
    // mask change in the middle of a word: "*" for the first byte, "??" after
    '{ROW_CFG,  CFG_PATTERN_LOW,  64'h2A, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h61, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LOW,  64'h3F3F, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd2, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h62, 1'b1, 1'b0, 1'b0},
    // all-zero registers: mask is a single NUL literal
    '{ROW_CFG,  CFG_PATTERN_LOW,  64'h0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_HIGH, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_PATTERN_LEN,  64'd1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{ROW_CHAR, CFG_PATTERN_LOW,  64'h0, 8'h00, 1'b1, 1'b0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  word_valid = 1'b0;
  logic                  word_ready;
  logic [7:0]            word_char = 8'h00;
  logic                  last_char = 1'b0;
  logic                  match_valid;
  logic                  match_ready = 1'b0;
  logic                  matched;

  // predictor copy of the config registers and the active-position vector
  logic [CFG_DATA_W-1:0] mask_lo  = PATTERN_LOW_RESET;
  logic [CFG_DATA_W-1:0] mask_hi  = PATTERN_HIGH_RESET;
  len_t                  mask_len = PATTERN_LEN_RESET;
  pos_t                  live_pos;

  bit match_expect_q[$];
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fails = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int mid_word_writes = 0;

  glob_word_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word_char   (word_char),
    .last_char   (last_char),
    .match_valid (match_valid),
    .match_ready (match_ready),
    .matched     (matched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // lengths above the mask store saturate
  function automatic int unsigned eff_len();
    return (mask_len > MASK_CHARS) ? MASK_CHARS : int'(mask_len);
  endfunction

  // characters past the two registers read as NUL
  function automatic logic [7:0] mask_byte(int unsigned i);
    if (i < 8) return mask_lo[8*i +: 8];
    if (i < 16) return mask_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  // drop positions past n, then let each live star position also enable the next
  function automatic pos_t close_stars(pos_t v, int unsigned n);
    pos_t r;
    r = v;
    for (int unsigned j = 0; j < POS_W; j++) begin
      if (j > n) r[j] = 1'b0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (r[i] && mask_byte(i) == STAR_CHAR) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  // advance the position vector by one byte; a last byte yields the match bit
  function automatic void apply_char(input logic [7:0] c, input logic last,
                                     output bit got, output bit hit);
    int unsigned n;
    pos_t        cur;
    pos_t        nxt;
    logic [7:0]  mb;
    n   = eff_len();
    cur = close_stars(live_pos, n);
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (cur[i]) begin
        mb = mask_byte(i);
        if (mb == STAR_CHAR) nxt[i] = 1'b1;
        else if (mb == QMARK_CHAR || mb == c) nxt[i+1] = 1'b1;
      end
    end
    nxt = close_stars(nxt, n);
    got = last;
    hit = last ? nxt[n] : 1'b0;
    live_pos = last ? close_stars(pos_t'(1), n) : nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Stop sending and wait for every outstanding match bit, then a few cycles
  // more so a trailing non-last byte has left the pipeline too.
  task automatic pause_sender();
    word_valid <= 1'b0;
    while (match_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One char transfer. Valid is left high on return; the next call either
  // replaces the payload or drops valid, always in the same time step.
  task automatic send_char(input logic [7:0] c, input logic last,
                           input bit has_exp, input bit exp_match);
    bit got;
    bit hit;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      word_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    word_valid <= 1'b1;
    word_char  <= c;
    last_char  <= last;
    @(posedge clk);
    while (!word_ready) @(posedge clk);
    apply_char(c, last, got, hit);
    if (got) match_expect_q.push_back(has_exp ? exp_match : hit);
    chars_sent++;
  endtask

  // Register writes only go out with the matcher drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    pause_sender();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PATTERN_LOW:  mask_lo  = data;
      CFG_PATTERN_HIGH: mask_hi  = data;
      CFG_PATTERN_LEN:  mask_len = data[LEN_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Random mask over a small alphabet so words built from it hit often;
  // a few raw bytes and odd lengths (zero, 16, saturated) mixed in.
  task automatic program_random_mask();
    logic [7:0]  mb;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int unsigned pick;
    int unsigned len_pick;
    for (int i = 0; i < 16; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) mb = STAR_CHAR;
      else if (pick == 2) mb = QMARK_CHAR;
      else if (pick == 3) mb = 8'($urandom_range(0, 255));
      else mb = 8'h61 + 8'($urandom_range(0, 2));
      if (i < 8) lo[8*i +: 8] = mb;
      else hi[8*(i-8) +: 8] = mb;
    end
    len_pick = $urandom_range(0, 19);
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    if (len_pick == 0) write_reg(CFG_PATTERN_LEN, CFG_DATA_W'($urandom_range(17, 31)));
    else if (len_pick == 1) write_reg(CFG_PATTERN_LEN, '0);
    else if (len_pick == 2) write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(MASK_CHARS));
    else write_reg(CFG_PATTERN_LEN, CFG_DATA_W'($urandom_range(1, 8)));
  endtask

  // Mostly words that follow the current mask (stars expanded to 0..3 chars,
  // question marks to any byte), some with one byte corrupted; the rest noise.
  task automatic build_word(output logic [7:0] wq[$]);
    logic [7:0] mb;
    int unsigned spot;
    wq = {};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) wq.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int unsigned i = 0; i < eff_len(); i++) begin
        mb = mask_byte(i);
        if (mb == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) wq.push_back(8'h61 + 8'($urandom_range(0, 2)));
        end else if (mb == QMARK_CHAR) begin
          wq.push_back(8'($urandom_range(0, 255)));
        end else begin
          wq.push_back(mb);
        end
      end
      if (wq.size() == 0) wq.push_back(8'h61 + 8'($urandom_range(0, 2)));
      if ($urandom_range(0, 3) == 0) begin
        spot = $urandom_range(0, wq.size() - 1);
        wq[spot] = ($urandom_range(0, 1) == 0) ? 8'h61 + 8'($urandom_range(0, 2))
                                               : 8'($urandom_range(0, 255));
      end
    end
  endtask

  // Result side: stalls in random bursts, none started once the run goes quiet.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      match_ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      match_ready <= 1'b0;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      match_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog, sampled at the edge the transfer happens
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (match_valid && match_ready) begin
        results_seen++;
        if (match_expect_q.size() == 0) begin
          $error("matched: result with no expectation waiting, actual %0b", matched);
          fails++;
        end else if (matched !== match_expect_q[0]) begin
          $error("matched: expected %0b, actual %0b", match_expect_q[0], matched);
          fails++;
          void'(match_expect_q.pop_front());
        end else begin
          void'(match_expect_q.pop_front());
        end
      end
      if ((match_valid && match_ready) || (word_valid && word_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, match_expect_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] wq[$];
    int         words_left;
    int         split;
    live_pos = close_stars(pos_t'(1), eff_len());
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].data);
      end else begin
        send_char(DIR_ROWS[r].ch, DIR_ROWS[r].last, DIR_ROWS[r].has_exp,
                  DIR_ROWS[r].exp_match);
      end
    end

    // random words, a new mask every few words
    words_left = 0;
    while (chars_sent < TARGET_CHARS) begin
      if (chars_sent >= QUIET_FROM) quiet = 1'b1;
      if (words_left == 0) begin
        program_random_mask();
        words_left = $urandom_range(4, 12);
      end
      build_word(wq);
      // now and then reprogram the mask halfway through a word
      split = (wq.size() >= 2 && $urandom_range(0, 24) == 0) ? wq.size() / 2 : -1;
      for (int k = 0; k < wq.size(); k++) begin
        if (k == split) begin
          program_random_mask();
          mid_word_writes++;
        end
        send_char(wq[k], k == wq.size() - 1, 1'b0, 1'b0);
      end
      words_left--;
      // now and then hold off until every match bit is back
      if (!quiet && $urandom_range(0, 19) == 0) pause_sender();
    end

    word_valid <= 1'b0;
    while (match_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d chars, %0d match results, %0d register writes",
             chars_sent, results_seen, cfg_writes);
    $display("including %0d mask changes within a word, %0d failures",
             mid_word_writes, fails);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: glob_word_matcher.f
hdl/gwm_pkg.sv
hdl/gwm_step.sv
hdl/glob_word_matcher.sv
hdl/gwm_checker.sv
dv/testbench.sv
